[design/fsky_pkg.sv]
// Package for the falling-squares skyline block: field widths, bus widths
// and parameter defaults. No dependencies.
package fsky_pkg;

  localparam int COL_W          = 11;   // left_pos, block_len, num_cols
  localparam int SPAN_W         = COL_W + 1;
  localparam int OUT_H_W        = 32;   // landed_top, skyline_max on the bus
  localparam int S_TDATA_W      = 24;   // two column fields, padded to bytes
  localparam int M_TDATA_W      = 64;
  localparam int M_TUSER_W      = 1;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int HEIGHT_BITS_DEF = 32;

  localparam logic [COL_W-1:0] NUM_COLS_RST = 11'd1024;

endpackage

[design/falling_squares_skyline_max_top.sv]
// Falling-squares skyline: range chmax / range max over a segment tree held
// in one node memory. Depends on fsky_pkg.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  s_*     | in  | s_tvalid / s_tready   | s_tdata: left_pos, block_len
//  m_*     | out | m_tvalid / m_tready   | m_tdata: landed_top, skyline_max;
//          |     |                       | m_tuser: range_error
//  cfg_*   | in  | cfg_valid / cfg_ready | cfg_data: num_cols
//
// An item walks the tree levels 0..L, L = clog2(MAX_COLS), twice through the
// single read/write port of the node memory: a query pass of up to 4 reads
// per level and an update pass of up to 4 read-modify-writes per level. An
// out-of-range item skips both passes. After reset a clearing pass zeroes all
// 2*2^L nodes of the node memory; s_tready stays low meanwhile, cfg writes
// are taken. A result waits in the output register while m_tready is low;
// the next item is taken once that result has been loaded.
module falling_squares_skyline_max_top #(
  parameter int MAX_COLS    = fsky_pkg::MAX_COLS_DEF,
  parameter int HEIGHT_BITS = fsky_pkg::HEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fsky_pkg::S_TDATA_W-1:0]  s_tdata,   // [10:0] left_pos, [21:11] block_len
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fsky_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] landed_top, [63:32] skyline_max
  output logic [fsky_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] range_error
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsky_pkg::COL_W-1:0]      cfg_data   // num_cols
);

  localparam int COL_W  = fsky_pkg::COL_W;
  localparam int HB     = HEIGHT_BITS;
  localparam int LOG    = $clog2(MAX_COLS);
  localparam int AW     = LOG + 1;            // node address
  localparam int IW     = AW + 1;             // half-open bounds reach 2*leaves
  localparam int NODES  = 2 << LOG;
  localparam int LVL_W  = $clog2(LOG + 1);
  localparam int EW_A   = $clog2(MAX_COLS + 1);
  localparam int EW     = (EW_A > fsky_pkg::SPAN_W) ? EW_A : fsky_pkg::SPAN_W;
  localparam int SW     = ((HB > COL_W) ? HB : COL_W) + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QRY   = 3'd2;
  localparam logic [2:0] ST_QEND  = 3'd3;
  localparam logic [2:0] ST_TOP   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic [1:0] SLOT_LAST = 2'd3;

  typedef struct packed {
    logic [HB-1:0] tag;   // largest value assigned with this node as a cover node
    logic [HB-1:0] mx;    // largest value assigned anywhere under this node
  } node_t;

  // control
  logic [2:0]       state;
  logic [AW-1:0]    clr_addr;
  logic [LVL_W-1:0] lvl;
  logic [1:0]       slot;
  logic             phase;
  logic             q_pend;
  logic [COL_W-1:0] num_cols;
  logic [HB-1:0]    gmax;

  // datapath
  logic [AW-1:0]    pl, pr;
  logic [IW-1:0]    lo, hi;
  logic [LOG-1:0]   lcol, rcol;
  logic [COL_W-1:0] len_q;
  logic [HB-1:0]    peak, top;
  logic             res_err;
  logic             q_canon;
  logic [fsky_pkg::OUT_H_W-1:0] out_top, out_sky;
  logic             out_err;

  node_t            tree_mem [NODES];
  node_t            mem_rdata, mem_wdata;
  logic [AW-1:0]    mem_raddr, mem_waddr;
  logic             mem_re, mem_we;

  // ---------------------------------------------------------------- input decode
  logic [COL_W-1:0] in_left, in_len;
  logic [EW-1:0]    in_sum, ncols_eff, in_lm1, in_rm1;
  logic             in_err, s_acc;

  assign in_left   = s_tdata[COL_W-1:0];
  assign in_len    = s_tdata[2*COL_W-1:COL_W];
  assign in_sum    = EW'(in_left) + EW'(in_len);
  assign ncols_eff = (EW'(num_cols) > EW'(MAX_COLS)) ? EW'(MAX_COLS) : EW'(num_cols);
  assign in_lm1    = EW'(in_left) - EW'(1);
  assign in_rm1    = in_sum - EW'(2);
  assign in_err    = (in_left == '0) || (in_len == '0) || ((in_sum - EW'(1)) > ncols_eff);
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- slot decode
  // Per level: two path nodes (ancestors of the end leaves) and up to two
  // cover nodes from the bottom-up bound walk.
  logic          lo_lt_hi, slot_en, slot_canon;
  logic [IW-1:0] hm1;
  logic [AW-1:0] slot_addr;

  assign lo_lt_hi = (lo < hi);
  assign hm1      = hi - IW'(1);

  always_comb begin
    slot_en    = 1'b1;
    slot_canon = 1'b0;
    slot_addr  = pl;
    case (slot)
      2'd0: begin
        slot_addr = pl;
      end
      2'd1: begin
        slot_addr = pr;
      end
      2'd2: begin
        slot_addr  = lo[AW-1:0];
        slot_en    = lo_lt_hi && lo[0];
        slot_canon = 1'b1;
      end
      default: begin
        slot_addr  = hm1[AW-1:0];
        slot_en    = lo_lt_hi && hi[0];
        slot_canon = 1'b1;
      end
    endcase
  end

  logic last_slot, last_lvl;
  assign last_slot = (slot == SLOT_LAST);
  assign last_lvl  = (lvl == LVL_W'(LOG));

  // ---------------------------------------------------------------- arithmetic
  logic [HB-1:0] lim, cand, top_calc, gmax_next;
  logic [SW-1:0] sum_w;
  logic          out_free;

  assign lim      = {HB{1'b1}};
  assign cand     = q_canon ? mem_rdata.mx : mem_rdata.tag;
  assign sum_w    = SW'(peak) + SW'(len_q);
  assign top_calc = (sum_w >= SW'(lim)) ? lim : sum_w[HB-1:0];
  assign gmax_next = (!res_err && (top > gmax)) ? top : gmax;
  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------- memory port
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = slot_addr;
    mem_waddr = slot_addr;
    mem_wdata = mem_rdata;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_QRY: begin
        mem_re = slot_en;
      end
      ST_UPD: begin
        mem_re = !phase && slot_en;
        mem_we = phase && slot_en;
        mem_wdata.mx  = (mem_rdata.mx > top) ? mem_rdata.mx : top;
        mem_wdata.tag = (slot_canon && (top > mem_rdata.tag)) ? top : mem_rdata.tag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= tree_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      lvl      <= '0;
      slot     <= '0;
      phase    <= 1'b0;
      q_pend   <= 1'b0;
      m_tvalid <= 1'b0;
      num_cols <= fsky_pkg::NUM_COLS_RST;
      gmax     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_cols <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      q_pend <= (state == ST_QRY) && slot_en;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          lvl   <= '0;
          slot  <= '0;
          phase <= 1'b0;
          if (s_acc) begin
            state <= in_err ? ST_FIN : ST_QRY;
          end
        end
        ST_QRY: begin
          slot <= slot + 2'd1;
          if (last_slot) begin
            lvl <= lvl + LVL_W'(1);
            if (last_lvl) begin
              state <= ST_QEND;
            end
          end
        end
        ST_QEND: begin
          state <= ST_TOP;
        end
        ST_TOP: begin
          lvl   <= '0;
          slot  <= '0;
          phase <= 1'b0;
          state <= ST_UPD;
        end
        ST_UPD: begin
          phase <= !phase;
          if (phase) begin
            slot <= slot + 2'd1;
            if (last_slot) begin
              lvl <= lvl + LVL_W'(1);
              if (last_lvl) begin
                state <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            gmax     <= gmax_next;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [HB+31:0] top_ext, sky_ext;
  assign top_ext = {32'b0, (res_err ? {HB{1'b0}} : top)};
  assign sky_ext = {32'b0, gmax_next};

  logic level_step;
  assign level_step = ((state == ST_QRY) && last_slot) || ((state == ST_UPD) && phase && last_slot);

  always_ff @(posedge clk) begin
    q_canon <= slot_canon;
    if (q_pend) begin
      peak <= (cand > peak) ? cand : peak;
    end
    if (s_acc) begin
      lcol    <= in_lm1[LOG-1:0];
      rcol    <= in_rm1[LOG-1:0];
      len_q   <= in_len;
      res_err <= in_err;
      peak    <= '0;
      pl      <= {1'b1, in_lm1[LOG-1:0]};
      pr      <= {1'b1, in_rm1[LOG-1:0]};
      lo      <= {2'b01, in_lm1[LOG-1:0]};
      hi      <= {2'b01, in_rm1[LOG-1:0]} + IW'(1);
    end
    if (state == ST_TOP) begin
      top <= top_calc;
      pl  <= {1'b1, lcol};
      pr  <= {1'b1, rcol};
      lo  <= {2'b01, lcol};
      hi  <= {2'b01, rcol} + IW'(1);
    end
    if (level_step) begin
      pl <= pl >> 1;
      pr <= pr >> 1;
      lo <= (lo + IW'(lo[0])) >> 1;
      hi <= (hi - IW'(hi[0])) >> 1;
    end
    if ((state == ST_FIN) && out_free) begin
      out_top <= top_ext[31:0];
      out_sky <= sky_ext[31:0];
      out_err <= res_err;
    end
  end

  assign m_tdata = {out_sky, out_top};
  assign m_tuser = out_err;

endmodule

[design/fsky_chk.sv]
// Port-level checker for the falling-squares skyline block, bound to the
// top level. Depends on fsky_pkg.
module fsky_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [fsky_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fsky_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [fsky_pkg::M_TUSER_W-1:0]  m_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [fsky_pkg::COL_W-1:0]      cfg_data
);

  // reset starts the clearing pass: no input taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!s_tready && !m_tvalid))
    else $error("busy state missing after reset");

  // one item at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while previous item in flight");

  // out-of-range items report a zero top
  a_error_top_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
    else $error("range error with nonzero landed_top");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed under stall");

endmodule

bind falling_squares_skyline_max_top fsky_chk u_fsky_chk (.*);
